FILE: rtl/fts_pkg.sv
// shared types, constants and arithmetic helpers for the finger drive block
`default_nettype none

package fts_pkg;

	localparam int FINGERS_DEF = 4;

	localparam int JW     = 26;
	localparam int CPL_W  = 24;
	localparam int DIV_W  = 20;
	localparam int SAT_W  = 28;
	localparam int PROD_W = 35;

	localparam int DIV_S = DIV_W + 3;
	localparam logic [DIV_S-2:0] DIV_M = (DIV_S-1)'((2 ** DIV_S) / 3);
	localparam logic [DIV_W:0] DIV_BIAS = (DIV_W+1)'(3 * (2 ** (DIV_W - 1)));
	localparam logic [DIV_W-1:0] DIV_HALF = DIV_W'(2 ** (DIV_W - 1));

	localparam logic [1:0] MODE_POS = 2'd0;
	localparam logic [1:0] MODE_VEL = 2'd1;
	localparam logic [1:0] MODE_TRQ = 2'd2;

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_GAIN = 2'd1;
	localparam logic [1:0] REG_BRK  = 2'd2;
	localparam logic [1:0] REG_HOLD = 2'd3;

	localparam logic [1:0]  MODE_RST = MODE_VEL;
	localparam logic [15:0] GAIN_RST = 16'd26;
	localparam logic [14:0] BRK_RST  = 15'd5120;
	localparam logic [15:0] HOLD_RST = 16'd0;

	typedef struct packed {
		logic [1:0]         finger;
		logic signed [15:0] angle_inner;
		logic signed [15:0] angle_outer;
		logic signed [15:0] vel_inner;
		logic signed [15:0] vel_outer;
		logic signed [15:0] link_load;
		logic signed [15:0] command;
	} in_word_t;

	typedef struct packed {
		logic               out_kind;
		logic signed [15:0] drive_inner;
		logic signed [15:0] drive_outer;
	} out_word_t;

	typedef struct packed {
		logic [1:0]         control_mode;
		logic [15:0]        vel_gain;
		logic [14:0]        brk_torque;
		logic signed [15:0] hold_angle;
	} cfg_t;

	typedef struct packed {
		logic [1:0]            finger;
		logic                  spread;
		logic                  inner_past;
		logic signed [15:0]    angle_outer;
		logic signed [15:0]    link_load;
		logic signed [15:0]    command;
		logic signed [JW-1:0]  jterm;
		logic signed [DIV_W-1:0] third_inner;
		logic signed [CPL_W-1:0] couple;
	} mid_t;

	// nearest integer to y/3, by reciprocal multiply and one correction
	function automatic logic signed [DIV_W-1:0] div3_round(input logic signed [DIV_W-1:0] y);
		logic [DIV_W:0]         z;
		logic [DIV_W+DIV_S-1:0] p;
		logic [DIV_W-1:0]       q;
		logic [DIV_W:0]         r;
		z = (DIV_W+1)'(y) + (DIV_W+1)'(1) + DIV_BIAS;
		p = (DIV_W+DIV_S)'(z) * (DIV_W+DIV_S)'(DIV_M);
		q = p[DIV_W+DIV_S-1:DIV_S];
		r = z - ((DIV_W+1)'(q) * (DIV_W+1)'(3));
		if (r >= (DIV_W+1)'(3)) begin
			q = q + DIV_W'(1);
		end
		return signed'(q - DIV_HALF);
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = SAT_W'(32767);
		lo = -SAT_W'(32768);
		if (v > hi) begin
			return 16'sh7fff;
		end else if (v < lo) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/fts_cfg_regs.sv
// configuration register bank
`default_nettype none

module fts_cfg_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [15:0]  cfg_data,
	output fts_pkg::cfg_t     cfg
);
	import fts_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.control_mode <= MODE_RST;
			cfg_q.vel_gain     <= GAIN_RST;
			cfg_q.brk_torque   <= BRK_RST;
			cfg_q.hold_angle   <= HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE: cfg_q.control_mode <= cfg_data[1:0];
				REG_GAIN: cfg_q.vel_gain     <= cfg_data;
				REG_BRK:  cfg_q.brk_torque   <= cfg_data[14:0];
				REG_HOLD: cfg_q.hold_angle   <= signed'(cfg_data);
				default:  cfg_q.control_mode <= cfg_q.control_mode;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/fts_front.sv
// input register and drive term stage: velocity gain multiply, coupling, inner third
`default_nettype none

module fts_front #(
	parameter int FINGERS = fts_pkg::FINGERS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fts_pkg::cfg_t     cfg,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire fts_pkg::in_word_t in_word,
	output logic                   mid_valid,
	input  wire logic              mid_stall,
	output fts_pkg::mid_t          mid_word
);
	import fts_pkg::*;

	in_word_t word_s1;
	logic     valid_s1;
	mid_t     mid_s2;
	logic     valid_s2;

	logic load_s1;
	logic load_s2;

	logic                     spread;
	logic signed [16:0]       vel_sum;
	logic signed [17:0]       vel_err;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [JW-1:0]     jterm;
	logic signed [16:0]       angle_diff;
	logic signed [DIV_W-1:0]  inner_x10;
	mid_t                     mid_d;

	assign load_s2  = valid_s1 && (!valid_s2 || !mid_stall);
	assign in_stall = valid_s1 && !load_s2;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			word_s1 <= in_word;
		end
	end

	always_comb begin
		spread     = 32'(word_s1.finger) >= 32'(FINGERS - 1);
		vel_sum    = spread ? 17'(word_s1.vel_inner)
		                    : 17'(word_s1.vel_inner) + 17'(word_s1.vel_outer);
		vel_err    = 18'(word_s1.command) - 18'(vel_sum);
		prod       = PROD_W'($signed({1'b0, cfg.vel_gain})) * PROD_W'(vel_err);
		prod_rnd   = prod + PROD_W'(128);
		case (cfg.control_mode)
			MODE_VEL: jterm = JW'(prod_rnd >>> 8);
			MODE_TRQ: jterm = JW'(word_s1.command);
			default:  jterm = '0;
		endcase
		angle_diff = 17'(word_s1.angle_inner) - 17'(word_s1.angle_outer);
		inner_x10  = DIV_W'(word_s1.angle_inner) * DIV_W'(10);

		mid_d.finger      = word_s1.finger;
		mid_d.spread      = spread;
		mid_d.inner_past  = word_s1.angle_inner > 16'sd20;
		mid_d.angle_outer = word_s1.angle_outer;
		mid_d.link_load   = word_s1.link_load;
		mid_d.command     = word_s1.command;
		mid_d.jterm       = jterm;
		mid_d.third_inner = div3_round(inner_x10);
		mid_d.couple      = CPL_W'(angle_diff) * CPL_W'(100);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (!mid_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			mid_s2 <= mid_d;
		end
	end

	assign mid_valid = valid_s2;
	assign mid_word  = mid_s2;

endmodule

`default_nettype wire

FILE: rtl/fts_switch.sv
// breakaway switch state, drive selection, saturation and result register
`default_nettype none

module fts_switch #(
	parameter int FINGERS = fts_pkg::FINGERS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire fts_pkg::cfg_t cfg,
	input  wire logic          mid_valid,
	output logic               mid_stall,
	input  wire fts_pkg::mid_t mid_word,
	output logic               out_valid,
	input  wire logic          out_stall,
	output fts_pkg::out_word_t out_word
);
	import fts_pkg::*;

	localparam int IDX_W = $clog2(FINGERS);

	logic [FINGERS-1:0]  engaged_q;
	logic signed [15:0]  held_q [FINGERS];
	out_word_t           out_s3;
	logic                out_valid_s3;

	logic                    accept;
	logic [IDX_W-1:0]        idx;
	logic                    eng_old;
	logic                    eng_new;
	logic                    load_high;
	logic                    j_neg;
	logic                    j_pos;
	logic                    pos_mode;
	logic                    upd_state;
	logic signed [SAT_W-1:0] jw;
	logic signed [SAT_W-1:0] cw;
	logic signed [SAT_W-1:0] aow;
	logic signed [SAT_W-1:0] bt_w;
	logic signed [DIV_W-1:0] j_clamped;
	out_word_t               out_d;

	assign mid_stall = out_valid_s3 && out_stall;
	assign accept    = mid_valid && !mid_stall;

	always_comb begin
		idx       = IDX_W'(mid_word.finger);
		eng_old   = engaged_q[idx];
		load_high = mid_word.link_load > signed'({1'b0, cfg.brk_torque});
		j_neg     = mid_word.jterm < 0;
		j_pos     = mid_word.jterm > 0;
		eng_new   = eng_old ? !(j_neg && mid_word.inner_past) : load_high;
		pos_mode  = cfg.control_mode == MODE_POS;
		upd_state = accept && !pos_mode && !mid_word.spread;

		jw   = SAT_W'(mid_word.jterm);
		cw   = SAT_W'(mid_word.couple);
		aow  = SAT_W'(mid_word.angle_outer);
		bt_w = SAT_W'(signed'({1'b0, cfg.brk_torque}));

		if (mid_word.jterm > JW'(262143)) begin
			j_clamped = DIV_W'(262143);
		end else if (mid_word.jterm < -JW'(262144)) begin
			j_clamped = -DIV_W'(262144);
		end else begin
			j_clamped = DIV_W'(mid_word.jterm);
		end

		if (pos_mode) begin
			out_d.out_kind = 1'b1;
			if (mid_word.spread) begin
				out_d.drive_inner = sat16(SAT_W'(0) - SAT_W'(mid_word.command));
				out_d.drive_outer = mid_word.command;
			end else begin
				out_d.drive_inner = mid_word.command;
				out_d.drive_outer = cfg.hold_angle;
			end
		end else begin
			out_d.out_kind = 1'b0;
			if (mid_word.spread) begin
				out_d.drive_inner = sat16(jw - cw);
				out_d.drive_outer = sat16(jw + cw);
			end else if (!eng_new) begin
				out_d.drive_inner = sat16(jw);
				out_d.drive_outer = sat16(SAT_W'(mid_word.third_inner) - aow * SAT_W'(10));
			end else if (j_pos) begin
				out_d.drive_inner = sat16(bt_w);
				out_d.drive_outer = sat16(SAT_W'(div3_round(j_clamped)));
			end else begin
				out_d.drive_inner = sat16(jw);
				out_d.drive_outer = sat16((SAT_W'(held_q[idx]) - aow) * SAT_W'(10));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			engaged_q <= '0;
			for (int i = 0; i < FINGERS; i++) begin
				held_q[i] <= '0;
			end
		end else if (upd_state) begin
			engaged_q[idx] <= eng_new;
			if (eng_new && j_pos) begin
				held_q[idx] <= mid_word.angle_outer;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s3 <= 1'b0;
		end else if (accept) begin
			out_valid_s3 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_s3 <= out_d;
		end
	end

	assign out_valid = out_valid_s3;
	assign out_word  = out_s3;

`ifndef NO_ASSERTIONS
	a_out_from_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_s3) |-> $past(mid_valid && !mid_stall))
		else $error("result word appeared without an accepted stage word");

	a_spread_keeps_switch: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mid_word.spread |=> $stable(engaged_q))
		else $error("spread word changed switch state");

	a_pos_keeps_switch: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cfg.control_mode == MODE_POS |=> $stable(engaged_q))
		else $error("position word changed switch state");

	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		mid_stall |=> out_valid_s3 && $stable(out_s3))
		else $error("result word lost while stalled");
`endif

endmodule

`default_nettype wire

FILE: rtl/finger_torque_switch_drive.sv
// finger drive law top level: config bank, drive term stage, switch stage
// an accepted word goes through the input, drive term and result registers
// throughput: one word per cycle when not stalled; the per-finger switch state
// is read and written in the switch stage in the same cycle, so words chain
// reset: mode velocity, gain 26, breakaway 5120, hold 0, all switches released,
// held outer angles zero, pipeline empty
`default_nettype none

module finger_torque_switch_drive #(
	parameter int FINGERS = fts_pkg::FINGERS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire fts_pkg::in_word_t in_word,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output fts_pkg::out_word_t     out_word
);
	import fts_pkg::*;

	cfg_t cfg;
	logic mid_valid;
	logic mid_stall;
	mid_t mid_word;

	fts_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fts_front #(
		.FINGERS (FINGERS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.mid_valid (mid_valid),
		.mid_stall (mid_stall),
		.mid_word  (mid_word)
	);

	fts_switch #(
		.FINGERS (FINGERS)
	) u_switch (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.mid_valid (mid_valid),
		.mid_stall (mid_stall),
		.mid_word  (mid_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// self-checking bench for the finger drive block: directed and random words against a drive-law predictor
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fts_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int LIMIT = 200000;

	class finger_drive_law;
		logic [1:0]  mode;
		longint      gain;
		longint      brk;
		longint      hold;
		bit          engaged[FINGERS_DEF];
		longint      held[FINGERS_DEF];
		out_word_t   drives_due[$];
		int          errors;

		function new();
			mode = MODE_RST;
			gain = GAIN_RST;
			brk = BRK_RST;
			hold = $signed(HOLD_RST);
			errors = 0;
			foreach (engaged[k]) begin
				engaged[k] = 1'b0;
				held[k] = 0;
			end
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] data);
			case (idx)
				REG_MODE: begin
					mode = data[1:0];
				end
				REG_GAIN: begin
					gain = data;
				end
				REG_BRK: begin
					brk = data[14:0];
				end
				REG_HOLD: begin
					hold = $signed(data);
				end
			endcase
		endfunction

		function longint third_nearest(longint y);
			longint t;
			t = y + 1;
			if (t >= 0) begin
				return t / 3;
			end
			return -((-t + 2) / 3);
		endfunction

		function logic signed [15:0] clamp16(longint v);
			if (v > 32767) begin
				return 16'sh7fff;
			end else if (v < -32768) begin
				return 16'sh8000;
			end
			return 16'(v);
		endfunction

		function int pending();
			return drives_due.size();
		endfunction

		function void take_update(in_word_t w);
			longint ai, ao, vi, vo, load, cmd, j, vsum, force_c, inner, outer;
			int f;
			bit spread;
			out_word_t e;
			f = w.finger;
			spread = (f >= FINGERS_DEF - 1);
			ai = w.angle_inner;
			ao = w.angle_outer;
			vi = w.vel_inner;
			vo = w.vel_outer;
			load = w.link_load;
			cmd = w.command;
			if (mode == MODE_POS) begin
				e.out_kind = 1'b1;
				if (spread) begin
					inner = -cmd;
					outer = cmd;
				end else begin
					inner = cmd;
					outer = hold;
				end
			end else begin
				e.out_kind = 1'b0;
				j = 0;
				if (mode == MODE_VEL) begin
					vsum = spread ? vi : vi + vo;
					j = (gain * (cmd - vsum) + 128) >>> 8;
				end else if (mode == MODE_TRQ) begin
					j = cmd;
				end
				if (spread) begin
					force_c = 100 * (ai - ao);
					inner = j - force_c;
					outer = j + force_c;
				end else begin
					if (!engaged[f]) begin
						if (load > brk) begin
							engaged[f] = 1'b1;
						end
					end else if (j < 0 && ai > 20) begin
						engaged[f] = 1'b0;
					end
					if (!engaged[f]) begin
						inner = j;
						outer = third_nearest(10 * ai - 30 * ao);
					end else if (j > 0) begin
						inner = brk;
						outer = third_nearest(j);
						held[f] = ao;
					end else begin
						inner = j;
						outer = 10 * (held[f] - ao);
					end
				end
			end
			e.drive_inner = clamp16(inner);
			e.drive_outer = clamp16(outer);
			drives_due = {drives_due, e};
		endfunction

		function void match_drive(out_word_t got);
			out_word_t e;
			if (drives_due.size() == 0) begin
				$display("%0t: unexpected word, actual kind %0d inner %0d outer %0d",
					$time, got.out_kind, got.drive_inner, got.drive_outer);
				errors++;
				return;
			end
			e = drives_due.pop_front();
			if (got.out_kind !== e.out_kind) begin
				$display("%0t: out_kind mismatch, expected %0d, actual %0d",
					$time, e.out_kind, got.out_kind);
				errors++;
			end
			if (got.drive_inner !== e.drive_inner) begin
				$display("%0t: drive_inner mismatch, expected %0d, actual %0d",
					$time, e.drive_inner, got.drive_inner);
				errors++;
			end
			if (got.drive_outer !== e.drive_outer) begin
				$display("%0t: drive_outer mismatch, expected %0d, actual %0d",
					$time, e.drive_outer, got.drive_outer);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_word_t    in_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_word_t   out_word;

	finger_drive_law law;
	int          tx_idle = 0;
	int          rx_idle = 0;
	int          rx_hold_left = 0;
	int unsigned cycles = 0;

	finger_torque_switch_drive i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: check accepted words, stall at random or for a long hold-off
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			law.match_drive(out_word);
		end
		if (rx_hold_left > 0) begin
			out_stall <= 1'b1;
			rx_hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle);
		end
	end

	function automatic in_word_t mk(int f, int ai, int ao, int vi, int vo, int load, int cmd);
		in_word_t w;
		w.finger = 2'(f);
		w.angle_inner = 16'(ai);
		w.angle_outer = 16'(ao);
		w.vel_inner = 16'(vi);
		w.vel_outer = 16'(vo);
		w.link_load = 16'(load);
		w.command = 16'(cmd);
		return w;
	endfunction

	function automatic logic [15:0] rand_q511();
		int v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = int'($urandom_range(65535));
			4, 5: v = int'($urandom_range(256)) - 128;
			6: begin
				case ($urandom_range(4))
					0: v = -32768;
					1: v = -1;
					2: v = 0;
					3: v = 1;
					default: v = 32767;
				endcase
			end
			default: v = int'($urandom_range(8191)) - 4096;
		endcase
		return 16'(v);
	endfunction

	function automatic in_word_t random_update();
		in_word_t w;
		w.finger = 2'($urandom_range(3));
		w.angle_inner = rand_q511();
		w.angle_outer = rand_q511();
		w.vel_inner = rand_q511();
		w.vel_outer = rand_q511();
		w.link_load = rand_q511();
		w.command = rand_q511();
		// push on the switch thresholds often
		if ($urandom_range(3) == 0) begin
			w.link_load = 16'(law.brk + longint'($urandom_range(4)) - 2);
		end
		if ($urandom_range(4) == 0) begin
			w.angle_inner = 16'(18 + int'($urandom_range(5)));
		end
		return w;
	endfunction

	task automatic send_update(in_word_t w);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		law.take_update(w);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (law.pending() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(logic [1:0] mode, logic [15:0] gain, logic [14:0] brk,
			logic [15:0] hold_pos);
		logic [1:0]  idx[4] = '{REG_MODE, REG_GAIN, REG_BRK, REG_HOLD};
		logic [15:0] val[4];
		val = '{16'(mode), gain, 16'(brk), hold_pos};
		for (int k = 0; k < 4; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			@(posedge clk);
			law.set_reg(idx[k], val[k]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(logic [1:0] mode, logic [15:0] gain, logic [14:0] brk,
			logic [15:0] hold_pos, int count, bit pause_mid, bit hold_mid);
		wait_drained();
		write_config(mode, gain, brk, hold_pos);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) begin
				if (pause_mid) begin
					wait_drained();
				end
				if (hold_mid) begin
					rx_hold_left = 300;
				end
			end
			send_update(random_update());
		end
	endtask

	initial begin
		law = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle = 31;
		rx_idle = 71;

		// reset settings: velocity mode, switch engage, hold and release
		send_update(mk(0, 0, 0, 0, 0, 0, 0));
		send_update(mk(0, 32767, 32767, 32767, 32767, 32767, 32767));
		send_update(mk(0, -32768, -32768, -32768, -32768, -32768, -32768));
		send_update(mk(3, 32767, -32768, 0, 32767, 32767, 100));
		send_update(mk(0, 20, 5, 0, 0, 0, -100));
		send_update(mk(0, 21, 5, 0, 0, 0, -100));
		send_update(mk(1, 0, 0, 0, 0, 5120, 0));
		send_update(mk(1, 100, -50, 10, 10, 5121, 500));
		send_update(mk(1, 21, 0, 0, 0, 0, 0));
		send_update(mk(2, -32768, 32767, -32768, -32768, -1, 32767));
		send_update(mk(3, -32768, 32767, 32767, -32768, 32767, -32768));

		wait_drained();
		write_config(MODE_POS, 16'd26, 15'd5120, 16'h8000);
		send_update(mk(0, 1, 2, 3, 4, 32767, 32767));
		send_update(mk(3, 1, 2, 3, 4, 5, -32768));
		send_update(mk(2, 0, 0, 0, 0, 0, -32768));
		send_update(mk(3, 0, 0, 0, 0, 0, 32767));

		// unused mode: zero drive term on the force path
		wait_drained();
		write_config(MODE_SPARE, 16'hffff, 15'd0, 16'h7fff);
		send_update(mk(0, 0, -32768, 5, 5, 1, 1000));
		send_update(mk(3, 1, 0, 0, 0, 0, 0));
		send_update(mk(2, 300, 100, 0, 0, -32768, 0));

		wait_drained();
		write_config(MODE_TRQ, 16'hffff, 15'h7fff, 16'd0);
		send_update(mk(1, 0, 0, 0, 0, 32767, 32767));
		send_update(mk(0, 32767, 0, 0, 0, 0, -32768));

		run_phase(MODE_VEL, 16'd26, 15'd5120, 16'd0, 150, 1'b0, 1'b0);
		run_phase(MODE_VEL, 16'hffff, 15'd0, 16'h7fff, 150, 1'b0, 1'b0);
		run_phase(MODE_TRQ, 16'd0, 15'h7fff, 16'h8000, 150, 1'b0, 1'b0);

		tx_idle = 71;
		rx_idle = 31;
		run_phase(MODE_POS, 16'd256, 15'd2048, 16'd1000, 100, 1'b0, 1'b0);
		run_phase(MODE_VEL, 16'd0, 15'h7fff, 16'd0, 150, 1'b1, 1'b0);
		run_phase(MODE_SPARE, 16'd512, 15'd100, 16'hfffb, 100, 1'b0, 1'b0);

		tx_idle = 0;
		rx_idle = 0;
		run_phase(MODE_TRQ, 16'd1000, 15'd2048, 16'd12345, 150, 1'b0, 1'b1);
		run_phase(MODE_VEL, 16'($urandom_range(65535)), 15'($urandom_range(32767)),
			16'($urandom_range(65535)), 250, 1'b0, 1'b0);

		wait_drained();
		repeat (8) @(posedge clk);
		if (law.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/fts_pkg.sv
rtl/fts_cfg_regs.sv
rtl/fts_front.sv
rtl/fts_switch.sv
rtl/finger_torque_switch_drive.sv
tb/testbench.sv
